// File: rtl/core/krt_pkg.sv
// Shared types and constants for the keyed record table.
// Holds the record, transaction and match structs and the state encoding.
// No dependencies.
`timescale 1ns / 1ps

package krt_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int COUNT_W         = 6;
  localparam int STATUS_W        = 2;

  // Most results a single list command may return
  localparam logic [COUNT_W-1:0] RES_LIMIT = 6'd32;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_LOOKUP   = 3'd1,
    CMD_COUNT    = 3'd2,
    CMD_LIST     = 3'd3,
    CMD_POSITION = 3'd4,
    CMD_REMOVE   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_RELOAD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic signed [15:0] region_x;
    logic signed [15:0] region_y;
    logic signed [15:0] local_x;
    logic signed [15:0] local_y;
    logic        [15:0] handle;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic        [2:0]         command;
    logic signed [15:0]        region_x;
    logic signed [15:0]        region_y;
    logic signed [15:0]        local_x;
    logic signed [15:0]        local_y;
    logic        [15:0]        handle;
    logic        [COUNT_W-1:0] max_count;
  } in_item_t;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic        [15:0]         out_handle;
    logic        [COUNT_W-1:0]  out_count;
    logic signed [15:0]         out_local_x;
    logic signed [15:0]         out_local_y;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic region;
    logic full;
    logic handle;
  } match_t;

endpackage

// File: rtl/core/krt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Parameterised on word width and depth; no dependencies.
`timescale 1ns / 1ps

module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/krt_match.sv
// Key comparator: checks one stored record against the command key.
// Depends on krt_pkg for rec_t and match_t.
`timescale 1ns / 1ps

module krt_match import krt_pkg::*; (
  input  rec_t   rec_i,
  input  rec_t   key_i,
  output match_t match_o
);

  logic region_eq;
  logic local_eq;

  assign region_eq = (rec_i.region_x == key_i.region_x) &&
                     (rec_i.region_y == key_i.region_y);
  assign local_eq  = (rec_i.local_x == key_i.local_x) &&
                     (rec_i.local_y == key_i.local_y);

  assign match_o.region = region_eq;
  assign match_o.full   = region_eq && local_eq;
  assign match_o.handle = (rec_i.handle == key_i.handle);

endmodule

// File: rtl/core/krt_seq.sv
// Command sequencer: walks the record memory, compacts on remove and
// drives the output register. Depends on krt_pkg; talks to krt_ram and krt_match.
`timescale 1ns / 1ps

module krt_seq import krt_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o,
  output logic            ram_we_o,
  output logic [AW-1:0]   ram_waddr_o,
  output rec_t            ram_wdata_o,
  output logic [AW-1:0]   ram_raddr_o,
  input  rec_t            ram_rdata_i,
  input  match_t          match_i,
  output rec_t            key_o
);

  state_e              state_q, state_d;
  in_item_t            cmd_q, cmd_d;
  logic [CW-1:0]       total_q, total_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [COUNT_W-1:0]  n_q, n_d;
  logic                pend_q, pend_d;
  logic [15:0]         pend_h_q, pend_h_d;
  out_item_t           res_q, res_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic [COUNT_W-1:0]  lim;
  logic [COUNT_W-1:0]  n_inc;
  logic [CW-1:0]       idx_inc;
  logic [CW-1:0]       tail;
  logic                out_free;
  logic                at_end;
  logic                list_hold;
  logic [CW-1:0]       raddr_full;

  assign lim       = (cmd_q.max_count > RES_LIMIT) ? RES_LIMIT : cmd_q.max_count;
  assign n_inc     = n_q + COUNT_W'(1);
  assign idx_inc   = idx_q + CW'(1);
  assign tail      = total_q - CW'(1);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign at_end    = (idx_q >= total_q) ||
                     ((cmd_q.command == CMD_LIST) && (n_q >= lim));
  // A new list hit cannot be parked while the previous one still waits
  assign list_hold = (cmd_q.command == CMD_LIST) && match_i.region && pend_q && !out_free;

  assign key_o.region_x = cmd_q.region_x;
  assign key_o.region_y = cmd_q.region_y;
  assign key_o.local_x  = cmd_q.local_x;
  assign key_o.local_y  = cmd_q.local_y;
  assign key_o.handle   = cmd_q.handle;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign ram_raddr_o = raddr_full[AW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.command)
            CMD_LOOKUP, CMD_COUNT, CMD_LIST, CMD_POSITION, CMD_REMOVE: state_d = S_SCAN;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (at_end) begin
          state_d = S_RESP;
        end else begin
          case (cmd_q.command)
            CMD_LOOKUP:   if (match_i.full) state_d = S_RESP;
            CMD_POSITION: if (match_i.handle) state_d = S_RESP;
            CMD_LIST: begin
              if (match_i.region && !list_hold && (n_inc == lim)) state_d = S_RESP;
            end
            CMD_REMOVE: begin
              if (match_i.region && (idx_q != tail)) state_d = S_MOVE;
            end
            default: state_d = S_SCAN;
          endcase
        end
      end
      S_MOVE:   state_d = S_RELOAD;
      S_RELOAD: state_d = S_SCAN;
      S_RESP:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cmd_d       = cmd_q;
    total_d     = total_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_h_d    = pend_h_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = total_q[AW-1:0];
    ram_wdata_o = ram_rdata_i;
    raddr_full  = idx_inc;

    case (state_q)
      S_IDLE: begin
        raddr_full = '0;
        if (in_valid_i) begin
          cmd_d        = in_item_i;
          idx_d        = '0;
          cnt_d        = '0;
          n_d          = '0;
          pend_d       = 1'b0;
          res_d        = '0;
          res_d.last   = 1'b1;
          res_d.status = ST_NOTFOUND;
          if (in_item_i.command == CMD_ADD) begin
            if (total_q >= CW'(DEPTH)) begin
              res_d.status    = ST_FULL;
              res_d.out_count = COUNT_W'(total_q);
            end else begin
              ram_we_o             = 1'b1;
              ram_wdata_o.region_x = in_item_i.region_x;
              ram_wdata_o.region_y = in_item_i.region_y;
              ram_wdata_o.local_x  = in_item_i.local_x;
              ram_wdata_o.local_y  = in_item_i.local_y;
              ram_wdata_o.handle   = in_item_i.handle;
              total_d              = total_q + CW'(1);
              res_d.status         = ST_OK;
              res_d.out_count      = COUNT_W'(total_q + CW'(1));
            end
          end
        end
      end

      S_SCAN: begin
        if (at_end) begin
          case (cmd_q.command)
            CMD_COUNT: begin
              res_d.status    = ST_OK;
              res_d.out_count = COUNT_W'(cnt_q);
            end
            CMD_LIST: begin
              if (pend_q) begin
                res_d.status     = ST_OK;
                res_d.out_handle = pend_h_q;
              end
            end
            CMD_REMOVE: begin
              res_d.status    = ST_OK;
              res_d.out_count = COUNT_W'(total_q);
            end
            default: res_d.status = ST_NOTFOUND;
          endcase
        end else begin
          idx_d = idx_inc;
          case (cmd_q.command)
            CMD_LOOKUP: begin
              if (match_i.full) begin
                res_d.status     = ST_OK;
                res_d.out_handle = ram_rdata_i.handle;
              end
            end
            CMD_COUNT: begin
              if (match_i.region) cnt_d = cnt_q + CW'(1);
            end
            CMD_POSITION: begin
              if (match_i.handle) begin
                res_d.status      = ST_OK;
                res_d.out_local_x = ram_rdata_i.local_x;
                res_d.out_local_y = ram_rdata_i.local_y;
              end
            end
            CMD_LIST: begin
              if (list_hold) begin
                // hold the current entry until the output register frees
                idx_d      = idx_q;
                raddr_full = idx_q;
              end else if (match_i.region) begin
                if (pend_q) begin
                  out_valid_d      = 1'b1;
                  out_d            = '0;
                  out_d.status     = ST_OK;
                  out_d.out_handle = pend_h_q;
                end
                n_d = n_inc;
                if (n_inc == lim) begin
                  res_d.status     = ST_OK;
                  res_d.out_handle = ram_rdata_i.handle;
                end else begin
                  pend_d   = 1'b1;
                  pend_h_d = ram_rdata_i.handle;
                end
              end
            end
            CMD_REMOVE: begin
              if (match_i.region) begin
                idx_d = idx_q;
                if (idx_q == tail) begin
                  total_d = tail;
                end else begin
                  raddr_full = tail;
                end
              end
            end
            default: idx_d = idx_q;
          endcase
        end
      end

      S_MOVE: begin
        // tail record is on the read port: drop it into the freed slot
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q[AW-1:0];
        ram_wdata_o = ram_rdata_i;
        total_d     = tail;
        raddr_full  = idx_q;
      end

      S_RELOAD: begin
        raddr_full = idx_q;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end

      default: raddr_full = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    n_q      <= n_d;
    pend_h_q <= pend_h_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

endmodule

// File: rtl/core/keyed_record_table.sv
// Top level of the keyed record table: record memory, key comparator and
// command sequencer. Depends on krt_pkg, krt_ram, krt_match and krt_seq.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------
//   in      | input     | in_valid_i/in_stall_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
// Add and unused codes go straight to the response state. Searches
// step one record per cycle through the single read port, pausing
// while a remove moves a tail record in (move and reload states) or
// a list hit waits on a stalled output. Reset clears the entry count,
// state, output valid and pending flag; records need no clearing pass.
`timescale 1ns / 1ps

module keyed_record_table import krt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  rec_t          ram_wdata;
  rec_t          ram_rdata;
  rec_t          key;
  match_t        match;

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  krt_match u_match (
    .rec_i   (ram_rdata),
    .key_i   (key),
    .match_o (match)
  );

  krt_seq #(
    .DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .match_i     (match),
    .key_o       (key)
  );

endmodule
